// File: src/edd_pkg.sv
// ----------------------------------------------------------------------------
// edd_pkg: shared types and constants for the 1 bpp error diffusion dither
// Item formats, configuration register indexes and sizing constants used by
// the front end, the pixel queue and the diffusion back end.
// ----------------------------------------------------------------------------
package edd_pkg;

  // Storage sizes.
  localparam int unsigned MAX_WIDTH   = 2048;
  localparam int unsigned PAL_DEPTH   = 256;
  localparam int unsigned QUEUE_DEPTH = 4;

  // Derived widths.
  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned PAL_AW  = $clog2(PAL_DEPTH);
  localparam int unsigned QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ERR_W   = 12;
  localparam int unsigned LW_W    = 12;
  localparam int unsigned FH_W    = 13;
  localparam int unsigned ROW_W   = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_ORDER    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

  // Configuration reset values and limits.
  localparam logic [LW_W-1:0] LINE_WIDTH_RST   = 12'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [LW_W-1:0] LINE_WIDTH_MAX   = 12'd2048;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_MAX = 13'd4096;

  // Request kinds.
  localparam logic REQ_PALETTE = 1'b0;
  localparam logic REQ_PIXEL   = 1'b1;

  // Quantiser constants.
  localparam logic signed [ERR_W-1:0] THRESHOLD = 12'sd128;
  localparam logic signed [ERR_W-1:0] LEVEL_MAX = 12'sd255;

  typedef struct packed {
    logic       req_type;
    logic [7:0] color_index;
    logic [7:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       row_end;
    logic       frame_end;
  } out_item_t;

  // One classified pixel travelling from the front end to the back end.
  typedef struct packed {
    logic [7:0]       level;
    logic [COL_W-1:0] col;
    logic             last_col;
    logic             last_row;
  } pix_t;

endpackage

// File: src/error_diffusion_dither_1bpp_top.sv
// ----------------------------------------------------------------------------
// error_diffusion_dither_1bpp_top: palette pixels to 1 bpp Floyd-Steinberg
// Raster-order error diffusion dither with a 256-entry palette, packing the
// dithered bits into bytes with row and frame end markers.
// ----------------------------------------------------------------------------
// The block takes one input beat per clock while it is not stalled, whether
// it is a palette write or a pixel, and gives at most one output byte for
// each pixel. Palette writes take effect for the very next pixel. Each pixel
// goes through a front end that reads the palette and tags the pixel with
// its place in the frame, a four-entry queue, and a back end that reads the
// line error store, adds the error from the left and from the row above,
// thresholds the sum and spreads the new error to the right and into the
// next row. The error from the left is held in a register for the next pixel,
// so the back end finishes one pixel per clock and the sustained rate is one
// pixel per clock while the output side takes its beats. The byte that a
// pixel completes passes the palette read register, the queue and the back
// end working stage before the output register offers it. The output register
// lets a new input beat be taken while a finished byte still waits. After
// reset the line error store is cleared by a pass over its 2048 entries,
// one entry a cycle, during which input beats are
// stalled; configuration writes are taken at any time but should be made only
// while the block is idle. A byte is emitted after eight pixels or at the end
// of a row; a partial byte keeps its bits at the first-pixel end, which is
// bit 0 or bit 7 as the bit order register selects when the byte is emitted.
// Line width is held to 1..2048 and frame height to 1..4096. When the last row
// of a frame has been dithered the line error store is left cleared again.
// ----------------------------------------------------------------------------
module error_diffusion_dither_1bpp_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  edd_pkg::in_item_t              in_data_i,
  output logic                           in_stall_o,
  output logic                           out_valid_o,
  output edd_pkg::out_item_t             out_data_o,
  input  logic                           out_stall_i,
  input  logic                           cfg_we_i,
  input  logic [edd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [edd_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  import edd_pkg::*;

  // Configuration registers.
  logic            bit_order_q;
  logic [LW_W-1:0] line_width_q;
  logic [FH_W-1:0] frame_height_q;

  // Links between the front end, the queue and the back end.
  logic              push;
  pix_t              push_data;
  logic              pop;
  logic              head_valid;
  pix_t              head;
  logic [QCNT_W-1:0] queue_count;
  logic              back_ready;

  // Writes to an index beyond the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_order_q    <= 1'b0;
      line_width_q   <= LINE_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BIT_ORDER:    bit_order_q    <= cfg_wdata_i[0];
        CFG_LINE_WIDTH:   line_width_q   <= cfg_wdata_i[LW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i[FH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The front end owns the palette and the column and row counters.
  edd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_data_i      (in_data_i),
    .in_stall_o     (in_stall_o),
    .line_width_i   (line_width_q),
    .frame_height_i (frame_height_q),
    .back_ready_i   (back_ready),
    .queue_count_i  (queue_count),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  // Classified pixels wait here so that either side can stall on its own.
  edd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head),
    .count_o      (queue_count)
  );

  // The back end owns the line error store and the packing of output bytes.
  edd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .bit_order_i  (bit_order_q),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o),
    .out_stall_i  (out_stall_i),
    .ready_o      (back_ready)
  );

endmodule

// File: src/edd_ram.sv
// ----------------------------------------------------------------------------
// edd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; the read data holds when no
// read is issued. A read at the address being written returns the old data.
// ----------------------------------------------------------------------------
module edd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/edd_front.sv
// ----------------------------------------------------------------------------
// edd_front: request intake and pixel classification
// Writes palette entries, looks up the level of each pixel and tags it with
// its column and its row and frame end flags before queueing it.
// ----------------------------------------------------------------------------
module edd_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  edd_pkg::in_item_t          in_data_i,
  output logic                       in_stall_o,
  input  logic [edd_pkg::LW_W-1:0]   line_width_i,
  input  logic [edd_pkg::FH_W-1:0]   frame_height_i,
  input  logic                       back_ready_i,
  input  logic [edd_pkg::QCNT_W-1:0] queue_count_i,
  output logic                       push_o,
  output edd_pkg::pix_t              push_data_o
);

  import edd_pkg::*;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             s1_v_q, s1_v_d;
  pix_t             s1_q, s1_d;

  logic             accept;
  logic             is_pixel;
  logic [LW_W-1:0]  width_eff;
  logic [FH_W-1:0]  height_eff;
  logic             last_col;
  logic             last_row;
  logic [7:0]       pal_rdata;
  logic [QCNT_W:0]  occupancy;

  // Room is reserved for the pixel whose palette read is in flight.
  assign occupancy  = {1'b0, queue_count_i} + {{QCNT_W{1'b0}}, s1_v_q};
  assign in_stall_o = !back_ready_i || (occupancy >= (QCNT_W+1)'(QUEUE_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;
  assign is_pixel   = (in_data_i.req_type == REQ_PIXEL);

  always_comb begin
    width_eff = line_width_i;
    if (line_width_i == '0) begin
      width_eff = LW_W'(1);
    end else if (line_width_i > LINE_WIDTH_MAX) begin
      width_eff = LINE_WIDTH_MAX;
    end
    height_eff = frame_height_i;
    if (frame_height_i == '0) begin
      height_eff = FH_W'(1);
    end else if (frame_height_i > FRAME_HEIGHT_MAX) begin
      height_eff = FRAME_HEIGHT_MAX;
    end
  end

  assign last_col = ((LW_W'(col_q) + LW_W'(1)) >= width_eff);
  assign last_row = ((FH_W'(row_q) + FH_W'(1)) >= height_eff);

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    s1_v_d = 1'b0;
    s1_d   = s1_q;
    if (accept && is_pixel) begin
      s1_v_d        = 1'b1;
      s1_d.level    = '0;
      s1_d.col      = col_q;
      s1_d.last_col = last_col;
      s1_d.last_row = last_row;
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      s1_v_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      s1_v_q <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  edd_ram #(
    .WIDTH (8),
    .DEPTH (PAL_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (accept && !is_pixel),
    .waddr_i (in_data_i.color_index[PAL_AW-1:0]),
    .wdata_i (in_data_i.entry_value),
    .re_i    (accept && is_pixel),
    .raddr_i (in_data_i.color_index[PAL_AW-1:0]),
    .rdata_o (pal_rdata)
  );

  // The level to dither is the complement of the palette value.
  always_comb begin
    push_data_o       = s1_q;
    push_data_o.level = ~pal_rdata;
  end
  assign push_o = s1_v_q;

endmodule

// File: src/edd_queue.sv
// ----------------------------------------------------------------------------
// edd_queue: short pixel queue between front end and back end
// Small circular buffer; the front end never pushes into a full queue.
// ----------------------------------------------------------------------------
module edd_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  edd_pkg::pix_t              push_data_i,
  input  logic                       pop_i,
  output logic                       head_valid_o,
  output edd_pkg::pix_t              head_o,
  output logic [edd_pkg::QCNT_W-1:0] count_o
);

  import edd_pkg::*;

  pix_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign count_o      = count_q;

endmodule

// File: src/edd_back.sv
// ----------------------------------------------------------------------------
// edd_back: error diffusion, quantisation and bit packing
// Holds the line error store, the right and below-pending errors and the
// packing shift register, and drives the output register.
// ----------------------------------------------------------------------------
module edd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  edd_pkg::pix_t       head_i,
  output logic                pop_o,
  input  logic                bit_order_i,
  output logic                out_valid_o,
  output edd_pkg::out_item_t  out_data_o,
  input  logic                out_stall_i,
  output logic                ready_o
);

  import edd_pkg::*;

  typedef logic signed [ERR_W-1:0] err_t;

  // Quotient by sixteen, truncated toward zero.
  function automatic err_t div16(input err_t x);
    err_t t;
    t = x[ERR_W-1] ? (x + err_t'(15)) : x;
    return t >>> 4;
  endfunction

  // Clearing pass over the line error store after reset.
  logic [COL_W-1:0] clr_cnt_q, clr_cnt_d;
  logic             clr_done_q, clr_done_d;

  // Working stage.
  logic             b2_v_q, b2_v_d;
  pix_t             b2_q;

  // Diffusion state.
  err_t             right_q, right_d;
  err_t             pend0_q, pend0_d;
  err_t             pend1_q, pend1_d;
  logic [2:0]       bit_cnt_q, bit_cnt_d;
  logic [7:0]       shift_q, shift_d;

  // Deferred second write at row end, and store read forwarding.
  logic             tail_v_q, tail_v_d;
  logic [COL_W-1:0] tail_addr_q, tail_addr_d;
  err_t             tail_data_q, tail_data_d;
  logic             ov_v_q, ov_v_d;
  err_t             ov_data_q, ov_data_d;

  // Output register.
  logic             out_v_q, out_v_d;
  out_item_t        out_q, out_d;

  logic             load, retire, emit, out_ready;
  logic             bit_val;
  logic [7:0]       byte_new, byte_rev;
  err_t             ram_rdata, nre, level_s, sum, err;
  err_t             e7, e5, e3, e1;
  err_t             data_a, data_b;
  logic             wr_a, wr_b;
  logic             we;
  logic [COL_W-1:0] waddr, target;
  err_t             wdata;

  // Error read for the stage being loaded, with writes landing that edge
  // or still deferred taking precedence over the stored value.
  always_comb begin
    if (tail_v_q && (tail_addr_q == b2_q.col)) begin
      nre = tail_data_q;
    end else if (ov_v_q) begin
      nre = ov_data_q;
    end else begin
      nre = ram_rdata;
    end
  end

  assign level_s = err_t'({4'b0000, b2_q.level});
  assign sum     = level_s + nre + right_q;
  assign bit_val = (sum >= THRESHOLD);
  assign err     = bit_val ? (sum - LEVEL_MAX) : sum;
  assign e7      = div16((err <<< 3) - err);
  assign e5      = div16((err <<< 2) + err);
  assign e3      = div16((err <<< 1) + err);
  assign e1      = div16(err);

  always_comb begin
    byte_new = shift_q;
    byte_new[bit_cnt_q] = bit_val;
    for (int k = 0; k < 8; k++) begin
      byte_rev[k] = byte_new[7-k];
    end
  end

  assign emit      = (bit_cnt_q == 3'd7) || b2_q.last_col;
  assign out_ready = !out_v_q || !out_stall_i;
  assign retire    = b2_v_q && (!emit || out_ready);
  assign load      = clr_done_q && head_valid_i && (!b2_v_q || retire);
  assign pop_o     = load;
  assign ready_o   = clr_done_q;

  // Stores below the current row; the last row writes zeros back.
  assign data_a = b2_q.last_row ? err_t'(0) : (pend0_q + e3);
  assign data_b = b2_q.last_row ? err_t'(0) : (pend1_q + e5);
  assign wr_a   = retire && (b2_q.col != '0);
  assign wr_b   = retire && b2_q.last_col;

  always_comb begin
    we          = 1'b0;
    waddr       = tail_addr_q;
    wdata       = tail_data_q;
    tail_v_d    = tail_v_q;
    tail_addr_d = tail_addr_q;
    tail_data_d = tail_data_q;
    clr_cnt_d   = clr_cnt_q;
    clr_done_d  = clr_done_q;
    if (!clr_done_q) begin
      we        = 1'b1;
      waddr     = clr_cnt_q;
      wdata     = '0;
      clr_cnt_d = clr_cnt_q + COL_W'(1);
      if (clr_cnt_q == COL_W'(MAX_WIDTH - 1)) begin
        clr_done_d = 1'b1;
      end
    end else if (wr_a) begin
      we    = 1'b1;
      waddr = b2_q.col - COL_W'(1);
      wdata = data_a;
      if (wr_b) begin
        tail_v_d    = 1'b1;
        tail_addr_d = b2_q.col;
        tail_data_d = data_b;
      end
    end else if (wr_b) begin
      we    = 1'b1;
      waddr = b2_q.col;
      wdata = data_b;
    end else if (tail_v_q) begin
      we       = 1'b1;
      tail_v_d = 1'b0;
    end
  end

  assign target = load ? head_i.col : b2_q.col;

  always_comb begin
    ov_v_d    = ov_v_q;
    ov_data_d = ov_data_q;
    if (we && (waddr == target)) begin
      ov_v_d    = 1'b1;
      ov_data_d = wdata;
    end else if (load) begin
      ov_v_d = 1'b0;
    end
  end

  always_comb begin
    b2_v_d    = (b2_v_q && !retire) || load;
    right_d   = right_q;
    pend0_d   = pend0_q;
    pend1_d   = pend1_q;
    bit_cnt_d = bit_cnt_q;
    shift_d   = shift_q;
    out_v_d   = out_v_q && out_stall_i;
    out_d     = out_q;
    if (retire) begin
      right_d = b2_q.last_col ? err_t'(0) : e7;
      if (b2_q.last_col || b2_q.last_row) begin
        pend0_d = '0;
        pend1_d = '0;
      end else begin
        pend0_d = pend1_q + e5;
        pend1_d = e1;
      end
      if (emit) begin
        bit_cnt_d       = '0;
        shift_d         = '0;
        out_v_d         = 1'b1;
        out_d.packed_byte = bit_order_i ? byte_rev : byte_new;
        out_d.row_end   = b2_q.last_col;
        out_d.frame_end = b2_q.last_col && b2_q.last_row;
      end else begin
        bit_cnt_d = bit_cnt_q + 3'd1;
        shift_d   = byte_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_done_q <= 1'b0;
      b2_v_q     <= 1'b0;
      right_q    <= '0;
      pend0_q    <= '0;
      pend1_q    <= '0;
      bit_cnt_q  <= '0;
      shift_q    <= '0;
      tail_v_q   <= 1'b0;
      ov_v_q     <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      clr_cnt_q  <= clr_cnt_d;
      clr_done_q <= clr_done_d;
      b2_v_q     <= b2_v_d;
      right_q    <= right_d;
      pend0_q    <= pend0_d;
      pend1_q    <= pend1_d;
      bit_cnt_q  <= bit_cnt_d;
      shift_q    <= shift_d;
      tail_v_q   <= tail_v_d;
      ov_v_q     <= ov_v_d;
      out_v_q    <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      b2_q <= head_i;
    end
    tail_addr_q <= tail_addr_d;
    tail_data_q <= tail_data_d;
    ov_data_q   <= ov_data_d;
    out_q       <= out_d;
  end

  edd_ram #(
    .WIDTH (ERR_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_err (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (load),
    .raddr_i (head_i.col),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// File: bench/tb_error_diffusion_dither_1bpp_top.sv
// ----------------------------------------------------------------------------
// tb_error_diffusion_dither_1bpp_top: self-checking bench for the 1 bpp dither
// Drives palette writes and pixels through the valid/stall input, predicts
// every packed byte with a shadow Floyd-Steinberg ditherer and checks the
// output beats in order, across several frame geometries and bit orders.
// ----------------------------------------------------------------------------
module tb_error_diffusion_dither_1bpp_top;
  timeunit 1ns;
  timeprecision 1ps;

  import edd_pkg::*;

  // Quantiser constants of the shadow ditherer.
  localparam int THRESH     = 128;
  localparam int FULL_SCALE = 255;
  localparam int HEIGHT_MAX = 4096;
  // Cycles the receiver refuses beats during the deliberate back-pressure test.
  localparam int HOLD_CYCLES = 60;
  // Margin that drain() waits after the last expected byte has left.
  localparam int SETTLE_CYCLES = 12;

  // --------------------------------------------------------------------------
  // Clock, reset and the ports of the block.
  // --------------------------------------------------------------------------
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  in_item_t              in_data_i   = '0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  out_item_t             out_data_o;
  logic                  out_stall_i = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = CFG_BIT_ORDER;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  error_diffusion_dither_1bpp_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Bench state. The stimulus process fills beats_pending; the driver drains
  // it. The scoreboard pushes predicted bytes into bytes_due when a pixel beat
  // is taken and pops them as output beats arrive.
  // --------------------------------------------------------------------------
  in_item_t  beats_pending[$];
  out_item_t bytes_due[$];
  logic      in_taken   = 1'b0;
  int        idle_pct   = 29;
  int        hold_asks  = 0;
  int        hold_served = 0;
  int        hold_left  = 0;
  int        mismatches = 0;

  // Palette entries the stimulus has already written; pixels only use these,
  // since an entry that was never written has no defined level.
  bit         pal_known [PAL_DEPTH];
  logic [7:0] known_idx [$];

  // Shadow copy of the block: registers, palette and diffusion state.
  logic        ord_msb;
  logic [11:0] cfg_width;
  logic [12:0] cfg_height;
  logic [7:0]  pal_lvl  [PAL_DEPTH];
  int          row_err  [MAX_WIDTH];
  int          carry_right;
  int          below_pend [2];
  int          col_cnt;
  int          row_cnt;
  int          bits_held;
  logic [7:0]  byte_acc;

  initial begin
    ord_msb     = 1'b0;
    cfg_width   = LINE_WIDTH_RST;
    cfg_height  = FRAME_HEIGHT_RST;
    carry_right = 0;
    below_pend[0] = 0;
    below_pend[1] = 0;
    col_cnt   = 0;
    row_cnt   = 0;
    bits_held = 0;
    byte_acc  = '0;
    for (int i = 0; i < MAX_WIDTH; i++) row_err[i] = 0;
    for (int i = 0; i < PAL_DEPTH; i++) begin
      pal_lvl[i]   = '0;
      pal_known[i] = 1'b0;
    end
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Dithers one pixel exactly as the block should, pushing the byte it
  // completes, if any. The error of the pixel is spread 7/16 to the right and
  // 3/16, 5/16 and 1/16 into the row below; the two rightmost below-row
  // contributions wait in below_pend until their column is final.
  task automatic dither_pixel(input logic [7:0] idx);
    int         w;
    int         h;
    int         col;
    int         acc;
    int         err;
    bit         pix_bit;
    bit         last_c;
    bit         last_r;
    logic [7:0] flipped;
    out_item_t  res;
    w = int'(cfg_width);
    if (w < 1) w = 1;
    if (w > int'(MAX_WIDTH)) w = int'(MAX_WIDTH);
    h = int'(cfg_height);
    if (h < 1) h = 1;
    if (h > HEIGHT_MAX) h = HEIGHT_MAX;
    col = col_cnt;
    if (col >= int'(MAX_WIDTH)) col = int'(MAX_WIDTH) - 1;
    // A width or height that shrank mid-frame ends the row or frame at once.
    last_c = (col + 1 >= w);
    last_r = (row_cnt + 1 >= h);

    acc = (FULL_SCALE - int'(pal_lvl[idx])) + row_err[col] + carry_right;
    if (acc < THRESH) begin
      pix_bit = 1'b0;
      err     = acc;
    end else begin
      pix_bit = 1'b1;
      err     = acc - FULL_SCALE;
    end

    carry_right = last_c ? 0 : (err * 7) / 16;
    if (!last_r) begin
      if (col > 0) row_err[col-1] = below_pend[0] + (err * 3) / 16;
      below_pend[0] = below_pend[1] + (err * 5) / 16;
      below_pend[1] = last_c ? 0 : err / 16;
      if (last_c) row_err[col] = below_pend[0];
    end else begin
      // On the last row the store is wiped behind the pixel, ready for the
      // next frame.
      if (col > 0) row_err[col-1] = 0;
      if (last_c) row_err[col] = 0;
      below_pend[0] = 0;
      below_pend[1] = 0;
    end

    byte_acc[bits_held] = pix_bit;
    bits_held++;
    if (bits_held >= 8 || last_c) begin
      // The bit order is the one in force when the byte leaves.
      for (int k = 0; k < 8; k++) flipped[7-k] = byte_acc[k];
      res.packed_byte = ord_msb ? flipped : byte_acc;
      res.row_end     = last_c;
      res.frame_end   = last_c && last_r;
      bytes_due.push_back(res);
      byte_acc  = '0;
      bits_held = 0;
    end

    if (last_c) begin
      col_cnt       = 0;
      carry_right   = 0;
      below_pend[0] = 0;
      below_pend[1] = 0;
      row_cnt = last_r ? 0 : ((row_cnt + 1) & 12'hFFF);
    end else begin
      col_cnt = col + 1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Scoreboard. Output beats are checked before the input beat of the same
  // edge is predicted; a pixel's byte never leaves on the edge that takes it.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : scoreboard
    out_item_t want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (bytes_due.size() == 0) begin
          note_mismatch($sformatf("unexpected byte %h row_end %b frame_end %b",
                                  out_data_o.packed_byte, out_data_o.row_end,
                                  out_data_o.frame_end));
        end else begin
          want = bytes_due.pop_front();
          if (out_data_o.packed_byte !== want.packed_byte ||
              out_data_o.row_end !== want.row_end ||
              out_data_o.frame_end !== want.frame_end) begin
            note_mismatch($sformatf(
              "byte exp %h/%b/%b got %h/%b/%b (byte/row_end/frame_end)",
              want.packed_byte, want.row_end, want.frame_end,
              out_data_o.packed_byte, out_data_o.row_end, out_data_o.frame_end));
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        if (in_data_i.req_type == REQ_PALETTE) begin
          pal_lvl[in_data_i.color_index] = in_data_i.entry_value;
        end else begin
          dither_pixel(in_data_i.color_index);
        end
      end
      in_taken <= in_valid_i && !in_stall_o;
    end
  end

  // --------------------------------------------------------------------------
  // Driver. A new beat is offered only once the previous one has been taken,
  // so a stalled payload stays put. Gaps are inserted at random.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : driver
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (beats_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= beats_pending.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. Stalls at random, and on request refuses every output beat for
  // a long stretch so that the internal queue fills and the input stalls.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : receiver
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_asks != hold_served) begin
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  function automatic in_item_t palette_beat(input logic [7:0] idx, input logic [7:0] val);
    in_item_t it;
    it.req_type    = REQ_PALETTE;
    it.color_index = idx;
    it.entry_value = val;
    if (!pal_known[idx]) begin
      pal_known[idx] = 1'b1;
      known_idx.push_back(idx);
    end
    return it;
  endfunction

  function automatic in_item_t pixel_beat(input logic [7:0] idx);
    in_item_t it;
    it.req_type    = REQ_PIXEL;
    it.color_index = idx;
    // The entry value field means nothing for a pixel; keep it moving anyway.
    it.entry_value = 8'($urandom);
    return it;
  endfunction

  // Mostly pixels over the entries written so far, with palette rewrites
  // sprinkled in so that levels change while a frame is in flight.
  function automatic in_item_t random_beat();
    logic [7:0] val;
    if ($urandom_range(99) < 20) begin
      case ($urandom_range(9))
        0:       val = 8'h00;
        1:       val = 8'hFF;
        default: val = 8'($urandom);
      endcase
      return palette_beat(8'($urandom_range(255)), val);
    end
    return pixel_beat(known_idx[$urandom_range(known_idx.size() - 1)]);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CFG_DATA_W'(val);
    case (idx)
      CFG_BIT_ORDER:    ord_msb    = val[0];
      CFG_LINE_WIDTH:   cfg_width  = val[11:0];
      CFG_FRAME_HEIGHT: cfg_height = val[12:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // The sender stays quiet until every predicted byte has arrived, then a
  // margin passes, since a trailing palette write leaves no byte to wait on.
  task automatic drain();
    while (beats_pending.size() != 0 || in_valid_i || bytes_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input int order, input int width, input int height,
                           input int beats);
    drain();
    write_reg(CFG_BIT_ORDER, order);
    write_reg(CFG_LINE_WIDTH, width);
    write_reg(CFG_FRAME_HEIGHT, height);
    for (int i = 0; i < beats; i++) beats_pending.push_back(random_beat());
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed beats at the reset geometry: the extreme and mid levels, a
    // pixel right after a palette write to its own entry, and a rewrite of
    // that entry. Fourteen pixels leave a partial byte open into the next phase.
    beats_pending.push_back(palette_beat(8'h00, 8'h00));
    beats_pending.push_back(palette_beat(8'hFF, 8'hFF));
    beats_pending.push_back(palette_beat(8'h80, 8'h80));
    beats_pending.push_back(palette_beat(8'h7F, 8'h7F));
    beats_pending.push_back(palette_beat(8'h55, 8'hAA));
    beats_pending.push_back(palette_beat(8'hAA, 8'h55));
    beats_pending.push_back(pixel_beat(8'h00));
    beats_pending.push_back(pixel_beat(8'hFF));
    beats_pending.push_back(pixel_beat(8'h80));
    beats_pending.push_back(pixel_beat(8'h7F));
    beats_pending.push_back(pixel_beat(8'h55));
    beats_pending.push_back(pixel_beat(8'hAA));
    beats_pending.push_back(pixel_beat(8'h00));
    beats_pending.push_back(pixel_beat(8'h00));
    beats_pending.push_back(pixel_beat(8'hFF));
    beats_pending.push_back(pixel_beat(8'hFF));
    beats_pending.push_back(palette_beat(8'h03, 8'd200));
    beats_pending.push_back(pixel_beat(8'h03));
    beats_pending.push_back(palette_beat(8'h03, 8'd10));
    beats_pending.push_back(pixel_beat(8'h03));
    beats_pending.push_back(pixel_beat(8'h80));
    beats_pending.push_back(pixel_beat(8'h7F));

    // One-pixel frames: every pixel closes its row and its frame. The open
    // partial byte from above leaves with the new bit order.
    run_phase(1, 1, 1, 30);
    // Zero sizes are held to one pixel and one row.
    run_phase(0, 0, 0, 20);
    // Widest row and tallest frame, only a stretch of the first row.
    run_phase(1, int'(LINE_WIDTH_MAX), int'(FRAME_HEIGHT_MAX), 90);
    // Shrinking the width mid-row ends the row at once; then small frames.
    run_phase(0, 5, 3, 120);
    // A long stretch with no idling on either side.
    idle_pct = 0;
    run_phase(1, 13, 4, 200);
    drain();
    idle_pct = 29;
    // Register values beyond the limits are held to the largest sizes.
    run_phase(0, 4095, 8191, 40);
    // Back-pressure: the receiver holds off while the sender keeps offering.
    run_phase(1, 8, 2, 150);
    hold_asks++;
    run_phase(0, 3, 9, 180);

    drain();
    if (bytes_due.size() != 0)
      note_mismatch($sformatf("%0d expected bytes never arrived", bytes_due.size()));
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: the whole run needs some tens of microseconds at most.
  initial begin : watchdog
    #400_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
